[rtl/core/nonpreemptive_priority_scheduler_unit_assert.svh]
// Assertion macros used by the checker file of this block.
`ifndef NONPREEMPTIVE_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH
`define NONPREEMPTIVE_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and held off during reset.
`define PNS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off during reset.
`define PNS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/pns_pkg.sv]
`timescale 1ns / 1ps
package pns_pkg;

  localparam int MaxJobs = 16;
  localparam int IdxW    = (MaxJobs > 1) ? $clog2(MaxJobs) : 1;
  localparam int CntW    = $clog2(MaxJobs + 1);

  localparam int ArrW    = 16;
  localparam int BurstW  = 16;
  localparam int PrioW   = 8;
  localparam int TickW   = 21;
  localparam int TatW    = 20;
  localparam int TotW    = 24;
  localparam int JobNumW = 5;

  typedef struct packed {
    logic [ArrW-1:0]   arrival;
    logic [BurstW-1:0] burst;
    logic [PrioW-1:0]  prio;
  } job_t;

  // Access requests from the sequencer to the job and completion memories.
  typedef struct packed {
    logic             job_we;
    logic [IdxW-1:0]  job_waddr;
    job_t             job_wdata;
    logic             cmp_we;
    logic [IdxW-1:0]  cmp_waddr;
    logic [TickW-1:0] cmp_wdata;
    logic             re;
    logic [IdxW-1:0]  raddr;
  } store_req_t;

  // Result load control from the sequencer to the output stage.
  typedef struct packed {
    logic               load;
    logic               first;
    logic               last;
    logic [JobNumW-1:0] job_num;
  } emit_t;

endpackage

[rtl/core/pns_store.sv]
`timescale 1ns / 1ps
module pns_store
  import pns_pkg::*;
(
  input  logic             clk_i,
  input  store_req_t       req_i,
  output job_t             job_rdata_o,
  output logic [TickW-1:0] cmp_rdata_o
);

  job_t             job_mem [MaxJobs];
  logic [TickW-1:0] cmp_mem [MaxJobs];

  // Both memories share one read address; read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (req_i.job_we) begin
      job_mem[req_i.job_waddr] <= req_i.job_wdata;
    end
    if (req_i.cmp_we) begin
      cmp_mem[req_i.cmp_waddr] <= req_i.cmp_wdata;
    end
    if (req_i.re) begin
      job_rdata_o <= job_mem[req_i.raddr];
      cmp_rdata_o <= cmp_mem[req_i.raddr];
    end
  end

endmodule

[rtl/core/pns_out.sv]
`timescale 1ns / 1ps
module pns_out
  import pns_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  emit_t              emit_i,
  input  job_t               job_i,
  input  logic [TickW-1:0]   completion_i,
  input  logic               out_stall_i,
  output logic               free_o,
  output logic               out_valid_o,
  output logic [JobNumW-1:0] job_number_o,
  output logic [TickW-1:0]   completion_time_o,
  output logic [TatW-1:0]    turnaround_time_o,
  output logic [TatW-1:0]    waiting_time_o,
  output logic [TotW-1:0]    total_turnaround_o,
  output logic [TotW-1:0]    total_waiting_o,
  output logic               last_result_o
);

  logic               valid_q;
  logic [JobNumW-1:0] num_q;
  logic [TickW-1:0]   cmp_q;
  logic [TatW-1:0]    tat_q, wt_q;
  logic [TotW-1:0]    tot_tat_q, tot_wt_q, tot_tat_d, tot_wt_d;
  logic [TotW-1:0]    out_tot_tat_q, out_tot_wt_q;
  logic               last_q;
  logic [TotW-1:0]    tat, wt;

  // Totals wrap modulo 2^24, so the per-job terms are formed at that width.
  assign tat       = TotW'(completion_i) - TotW'(job_i.arrival);
  assign wt        = tat - TotW'(job_i.burst);
  assign tot_tat_d = emit_i.first ? tat : tot_tat_q + tat;
  assign tot_wt_d  = emit_i.first ? wt : tot_wt_q + wt;

  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (emit_i.load) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.load) begin
      num_q         <= emit_i.job_num;
      cmp_q         <= completion_i;
      tat_q         <= tat[TatW-1:0];
      wt_q          <= wt[TatW-1:0];
      tot_tat_q     <= tot_tat_d;
      tot_wt_q      <= tot_wt_d;
      out_tot_tat_q <= emit_i.last ? tot_tat_d : '0;
      out_tot_wt_q  <= emit_i.last ? tot_wt_d : '0;
      last_q        <= emit_i.last;
    end
  end

  assign out_valid_o        = valid_q;
  assign job_number_o       = num_q;
  assign completion_time_o  = cmp_q;
  assign turnaround_time_o  = tat_q;
  assign waiting_time_o     = wt_q;
  assign total_turnaround_o = out_tot_tat_q;
  assign total_waiting_o    = out_tot_wt_q;
  assign last_result_o      = last_q;

endmodule

[rtl/core/pns_ctrl.sv]
`timescale 1ns / 1ps
module pns_ctrl
  import pns_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ArrW-1:0]   arrival_time_i,
  input  logic [BurstW-1:0] burst_time_i,
  input  logic [PrioW-1:0]  priority_req_i,
  input  logic              last_job_i,
  output store_req_t        req_o,
  input  job_t              job_rdata_i,
  input  logic              out_free_i,
  output emit_t             emit_o
);

  localparam logic [2:0] S_LOAD      = 3'd0;
  localparam logic [2:0] S_SCAN      = 3'd1;
  localparam logic [2:0] S_COMMIT    = 3'd2;
  localparam logic [2:0] S_EMIT_RD   = 3'd3;
  localparam logic [2:0] S_EMIT_WAIT = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   done_q, done_d;
  logic [TickW-1:0]  tick_q, tick_d;
  logic [MaxJobs-1:0] fin_q, fin_d;
  logic [CntW-1:0]   issue_q, issue_d;
  logic              rv_q, rv_d;
  logic [CntW-1:0]   rv_idx_q, rv_idx_d;
  logic              found_q, found_d;
  logic              pend_q, pend_d;
  logic [IdxW-1:0]   pick_q, pick_d;
  logic [PrioW-1:0]  best_prio_q, best_prio_d;
  logic [ArrW-1:0]   best_arr_q, best_arr_d;
  logic [BurstW-1:0] best_burst_q, best_burst_d;
  logic [ArrW-1:0]   next_arr_q, next_arr_d;
  logic [CntW-1:0]   emit_idx_q, emit_idx_d;

  logic              live, ready, better, scan_end, emit_last;
  logic [TickW-1:0]  finish_tick;

  assign live     = rv_q && !fin_q[rv_idx_q[IdxW-1:0]];
  assign ready    = live && (TickW'(job_rdata_i.arrival) <= tick_q);
  assign better   = !found_q || (job_rdata_i.prio < best_prio_q) ||
                    ((job_rdata_i.prio == best_prio_q) &&
                     (job_rdata_i.arrival < best_arr_q));
  assign scan_end = rv_q && (rv_idx_q == count_q - 1'b1);
  assign emit_last   = (emit_idx_q == count_q - 1'b1);
  assign finish_tick = tick_q + TickW'(best_burst_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    done_d       = done_q;
    tick_d       = tick_q;
    fin_d        = fin_q;
    issue_d      = issue_q;
    rv_d         = 1'b0;
    rv_idx_d     = issue_q;
    found_d      = found_q;
    pend_d       = pend_q;
    pick_d       = pick_q;
    best_prio_d  = best_prio_q;
    best_arr_d   = best_arr_q;
    best_burst_d = best_burst_q;
    next_arr_d   = next_arr_q;
    emit_idx_d   = emit_idx_q;
    in_stall_o   = 1'b1;
    req_o        = '0;
    req_o.job_waddr = count_q[IdxW-1:0];
    req_o.job_wdata = '{arrival: arrival_time_i, burst: burst_time_i, prio: priority_req_i};
    req_o.cmp_waddr = pick_q;
    req_o.cmp_wdata = finish_tick;
    req_o.raddr     = issue_q[IdxW-1:0];
    emit_o          = '0;
    emit_o.first    = (emit_idx_q == '0);
    emit_o.last     = emit_last;
    emit_o.job_num  = JobNumW'({1'b0, emit_idx_q} + 1'b1);

    case (state_q)
      S_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          // A word beyond the set limit is dropped, but its last flag still counts.
          if (count_q < CntW'(MaxJobs)) begin
            req_o.job_we = 1'b1;
            count_d      = count_q + 1'b1;
          end
          if (last_job_i) begin
            state_d = S_SCAN;
            issue_d = '0;
            found_d = 1'b0;
            pend_d  = 1'b0;
          end
        end
      end
      S_SCAN: begin
        if (issue_q < count_q) begin
          req_o.re = 1'b1;
          issue_d  = issue_q + 1'b1;
          rv_d     = 1'b1;
        end
        if (live) begin
          if (!pend_q || (job_rdata_i.arrival < next_arr_q)) begin
            next_arr_d = job_rdata_i.arrival;
          end
          pend_d = 1'b1;
        end
        if (ready && better) begin
          found_d      = 1'b1;
          pick_d       = rv_idx_q[IdxW-1:0];
          best_prio_d  = job_rdata_i.prio;
          best_arr_d   = job_rdata_i.arrival;
          best_burst_d = job_rdata_i.burst;
        end
        if (scan_end) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        issue_d = '0;
        found_d = 1'b0;
        pend_d  = 1'b0;
        state_d = S_SCAN;
        if (found_q) begin
          req_o.cmp_we  = 1'b1;
          tick_d        = finish_tick;
          fin_d[pick_q] = 1'b1;
          done_d        = done_q + 1'b1;
          if (done_q + 1'b1 == count_q) begin
            state_d    = S_EMIT_RD;
            emit_idx_d = '0;
          end
        end else begin
          // Nothing has arrived yet: jump straight to the earliest arrival.
          tick_d = TickW'(next_arr_q);
        end
      end
      S_EMIT_RD: begin
        req_o.re    = 1'b1;
        req_o.raddr = emit_idx_q[IdxW-1:0];
        state_d     = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (out_free_i) begin
          emit_o.load = 1'b1;
          if (emit_last) begin
            state_d = S_LOAD;
            count_d = '0;
            done_d  = '0;
            tick_d  = '0;
            fin_d   = '0;
          end else begin
            emit_idx_d = emit_idx_q + 1'b1;
            state_d    = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      count_q    <= '0;
      done_q     <= '0;
      tick_q     <= '0;
      fin_q      <= '0;
      issue_q    <= '0;
      rv_q       <= 1'b0;
      found_q    <= 1'b0;
      pend_q     <= 1'b0;
      emit_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      done_q     <= done_d;
      tick_q     <= tick_d;
      fin_q      <= fin_d;
      issue_q    <= issue_d;
      rv_q       <= rv_d;
      found_q    <= found_d;
      pend_q     <= pend_d;
      emit_idx_q <= emit_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rv_idx_q     <= rv_idx_d;
    pick_q       <= pick_d;
    best_prio_q  <= best_prio_d;
    best_arr_q   <= best_arr_d;
    best_burst_q <= best_burst_d;
    next_arr_q   <= next_arr_d;
  end

endmodule

[rtl/core/nonpreemptive_priority_scheduler_unit.sv]
`timescale 1ns / 1ps
// Non-preemptive priority scheduler. Jobs (arrival, burst, priority) are loaded one
// word per cycle, up to 16 per set; further words are dropped. The word with
// last_job set closes the set and starts scheduling from tick 0: each decision is
// one pass over the N stored jobs through the single read port of the job memory,
// then a commit state, and there are N decisions plus at most N passes that only
// advance time to the earliest pending arrival. Results then leave in load order,
// each read from memory and then loaded into the output register once it is free,
// with the totals on the last one. The input is stalled from the last word of a set
// until the last result of that set has entered the output register.
module nonpreemptive_priority_scheduler_unit
  import pns_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ArrW-1:0]    arrival_time_i,
  input  logic [BurstW-1:0]  burst_time_i,
  input  logic [PrioW-1:0]   priority_req_i,
  input  logic               last_job_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [JobNumW-1:0] job_number_o,
  output logic [TickW-1:0]   completion_time_o,
  output logic [TatW-1:0]    turnaround_time_o,
  output logic [TatW-1:0]    waiting_time_o,
  output logic [TotW-1:0]    total_turnaround_o,
  output logic [TotW-1:0]    total_waiting_o,
  output logic               last_result_o
);

  store_req_t       store_req;
  job_t             job_rdata;
  logic [TickW-1:0] cmp_rdata;
  emit_t            emit;
  logic             out_free;

  pns_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .arrival_time_i (arrival_time_i),
    .burst_time_i   (burst_time_i),
    .priority_req_i (priority_req_i),
    .last_job_i     (last_job_i),
    .req_o          (store_req),
    .job_rdata_i    (job_rdata),
    .out_free_i     (out_free),
    .emit_o         (emit)
  );

  pns_store u_store (
    .clk_i       (clk_i),
    .req_i       (store_req),
    .job_rdata_o (job_rdata),
    .cmp_rdata_o (cmp_rdata)
  );

  pns_out u_out (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .emit_i             (emit),
    .job_i              (job_rdata),
    .completion_i       (cmp_rdata),
    .out_stall_i        (out_stall_i),
    .free_o             (out_free),
    .out_valid_o        (out_valid_o),
    .job_number_o       (job_number_o),
    .completion_time_o  (completion_time_o),
    .turnaround_time_o  (turnaround_time_o),
    .waiting_time_o     (waiting_time_o),
    .total_turnaround_o (total_turnaround_o),
    .total_waiting_o    (total_waiting_o),
    .last_result_o      (last_result_o)
  );

endmodule

[rtl/core/pns_checker.sv]
`timescale 1ns / 1ps
`include "nonpreemptive_priority_scheduler_unit_assert.svh"
module pns_checker
  import pns_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [JobNumW-1:0] job_number_o,
  input logic [TickW-1:0]   completion_time_o,
  input logic [TatW-1:0]    turnaround_time_o,
  input logic [TatW-1:0]    waiting_time_o,
  input logic [TotW-1:0]    total_turnaround_o,
  input logic [TotW-1:0]    total_waiting_o,
  input logic               last_result_o
);

  `PNS_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "stalled result dropped")
  `PNS_ASSERT_NXT(a_out_stable, out_valid_o && out_stall_i, $stable(job_number_o) && $stable(completion_time_o) && $stable(total_turnaround_o) && $stable(last_result_o), "stalled result changed")
  `PNS_ASSERT_IMP(a_totals_zero, out_valid_o && !last_result_o, total_turnaround_o == '0 && total_waiting_o == '0, "totals on a result that is not last")
  `PNS_ASSERT_IMP(a_times_order, out_valid_o, waiting_time_o <= turnaround_time_o && job_number_o != '0, "waiting exceeds turnaround or job number zero")

endmodule

bind nonpreemptive_priority_scheduler_unit pns_checker u_pns_checker (.*);
